FILE: hw/rtl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants of the text terminal buffer
// Field widths, screen defaults, item kinds, control codes, FSM states.
// ----------------------------------------------------------------------------
package ttb_pkg;

	// fixed payload field widths
	localparam int KIND_W = 2;
	localparam int CHAR_W = 8;
	localparam int TTY_W  = 4;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int IDX_W  = 2;
	localparam int SCROLL_BITS = 4;

	// default screen geometry
	localparam int DEF_SCREEN_WIDTH   = 80;
	localparam int DEF_SCREEN_HEIGHT  = 25;
	localparam int DEF_TERMINAL_COUNT = 4;
	localparam int DEF_TAB_STEP       = 4;

	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [CHAR_W-1:0] CHR_BS  = 8'd8;
	localparam logic [CHAR_W-1:0] CHR_TAB = 8'd9;
	localparam logic [CHAR_W-1:0] CHR_LF  = 8'd10;
	localparam logic [CHAR_W-1:0] CHR_CR  = 8'd13;

	typedef enum logic [KIND_W-1:0] {
		KIND_CHAR         = 2'd0,
		KIND_SELECT       = 2'd1,
		KIND_READ         = 2'd2,
		KIND_REFRESH_DONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY,
		ST_DRAIN,
		ST_BLANK,
		ST_RESP
	} state_t;

endpackage

FILE: hw/rtl/ttb_item_if.sv
// ----------------------------------------------------------------------------
// ttb_item_if: input item channel
// Valid/ready handshake with the item payload.
// ----------------------------------------------------------------------------
interface ttb_item_if;
	import ttb_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CHAR_W-1:0] char_code;
	logic [TTY_W-1:0]  tty_number;
	logic [ROW_W-1:0]  read_row;
	logic [COL_W-1:0]  read_col;

	modport source (output valid, kind, char_code, tty_number, read_row, read_col,
		input ready);
	modport sink (input valid, kind, char_code, tty_number, read_row, read_col,
		output ready);

endinterface

FILE: hw/rtl/ttb_result_if.sv
// ----------------------------------------------------------------------------
// ttb_result_if: result channel
// Valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface ttb_result_if;
	import ttb_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] cell_char;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;
	logic [IDX_W-1:0]  active_index;
	logic              refresh_pending;
	logic              select_error;

	modport source (output valid, cell_char, cursor_col, cursor_row, active_index,
		refresh_pending, select_error, input ready);
	modport sink (input valid, cell_char, cursor_col, cursor_row, active_index,
		refresh_pending, select_error, output ready);

endinterface

FILE: hw/rtl/ttb_ram.sv
// ----------------------------------------------------------------------------
// ttb_ram: generic single-write, single-read RAM
// One write port, one read port with registered data held while not read.
// ----------------------------------------------------------------------------
module ttb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/text_terminal_buffer.sv
// ----------------------------------------------------------------------------
// text_terminal_buffer: character screens for several virtual terminals
// Cursor handling, wrap or scroll on overflow, cell reads for display scan.
// ----------------------------------------------------------------------------
// Usage:
//   item   : sink channel. kind 0 writes a character to the active terminal,
//            kind 1 selects a terminal, kind 2 reads a cell, kind 3 clears the
//            active terminal's refresh flag.
//   result : source channel, one transaction per item: cell read (else zero),
//            active cursor, active index, refresh flag and select error.
//   cfg_wr_en/cfg_wr_data : scroll enable bits, one per terminal; write only
//            while no item is in flight.
// Flow: an item is accepted, then loaded into the output register in RESP.
//   A character that overflows the column on a scrolling terminal adds a
//   screen copy through the single RAM port pair: a pipelined read/write
//   that moves rows 1 to H-1 up one row (COPY), a drain step (DRAIN) and
//   the blanking of the bottom row (BLANK). The next item is taken while
//   a result still sits in the output register; a stalled receiver holds
//   the result and stops the block once the next result is ready to load.
// Reset: the screen RAM is swept to zero, one entry a cycle, over
//   2^(TW+RW+CW) entries (16384 at the defaults); item.ready stays low
//   during the sweep. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module text_terminal_buffer import ttb_pkg::*; #(
	parameter int SCREEN_WIDTH   = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT  = DEF_SCREEN_HEIGHT,
	parameter int TERMINAL_COUNT = DEF_TERMINAL_COUNT,
	parameter int TAB_STEP       = DEF_TAB_STEP
) (
	input  logic                   clk,
	input  logic                   arst_n,
	ttb_item_if.sink               item,
	ttb_result_if.source           result,
	input  logic                   cfg_wr_en,
	input  logic [SCROLL_BITS-1:0] cfg_wr_data
);

	// address = {terminal, row, column}, each field padded to a power of two
	localparam int CW    = $clog2(SCREEN_WIDTH);
	localparam int RW    = $clog2(SCREEN_HEIGHT);
	localparam int TW    = (TERMINAL_COUNT > 1) ? $clog2(TERMINAL_COUNT) : 1;
	localparam int AW    = TW + RW + CW;
	localparam int DEPTH = 1 << AW;

	localparam logic [CW-1:0] COL_LAST  = CW'(SCREEN_WIDTH - 1);
	localparam logic [RW-1:0] ROW_LAST  = RW'(SCREEN_HEIGHT - 1);
	localparam logic [CW:0]   COL_LIMIT = (CW+1)'(SCREEN_WIDTH);
	localparam logic [RW:0]   ROW_LIMIT = (RW+1)'(SCREEN_HEIGHT);
	localparam logic [CW:0]   TAB_MOD   = (CW+1)'(TAB_STEP % SCREEN_WIDTH);
	localparam logic [ROW_W:0] RD_ROW_LIMIT = (ROW_W+1)'(SCREEN_HEIGHT);
	localparam logic [COL_W:0] RD_COL_LIMIT = (COL_W+1)'(SCREEN_WIDTH);
	localparam logic [TTY_W:0] TTY_LIMIT    = (TTY_W+1)'(TERMINAL_COUNT);

	state_t state_q, state_d;

	// per-terminal cursor and refresh state
	logic [CW-1:0]             col_q [TERMINAL_COUNT];
	logic [RW-1:0]             row_q [TERMINAL_COUNT];
	logic [TERMINAL_COUNT-1:0] flag_q;
	logic [TW-1:0]             act_q;
	logic [SCROLL_BITS-1:0]    scroll_q;

	// sweep and copy counters
	logic [AW-1:0] clr_addr_q;
	logic [RW-1:0] ptr_row_q;
	logic [CW-1:0] ptr_col_q;

	// copy write pipeline
	logic          wr_s1;
	logic [AW-1:0] waddr_s1;

	logic err_q;
	logic cell_sel_q;

	// output register
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_cell_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_flag_q;
	logic              out_err_q;

	// RAM port
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [CHAR_W-1:0] ram_wdata, ram_rdata;

	// character step
	logic [CW-1:0] cur_col;
	logic [RW-1:0] cur_row;
	logic [3:0]    act_ext;
	logic          scroll_mode;
	logic [CW:0]   col_inc, tab_sum;
	logic [CW-1:0] tab_col;
	logic [RW:0]   row_inc;
	logic [RW-1:0] row_adv;
	logic [CW-1:0] step_col, step_wcol;
	logic [RW-1:0] step_row;
	logic          step_we, step_scroll;
	logic [CHAR_W-1:0] step_wdata;

	logic accept, load_out, rd_in_range, tty_in_range;
	kind_t kind;

	assign kind         = kind_t'(item.kind);
	assign accept       = item.valid && item.ready;
	assign rd_in_range  = ({1'b0, item.read_row} < RD_ROW_LIMIT) &&
		({1'b0, item.read_col} < RD_COL_LIMIT);
	assign tty_in_range = {1'b0, item.tty_number} < TTY_LIMIT;

	assign cur_col     = col_q[act_q];
	assign cur_row     = row_q[act_q];
	assign act_ext     = 4'(act_q);
	// terminals beyond the scroll bits always wrap
	assign scroll_mode = (act_ext < 4'(SCROLL_BITS)) && scroll_q[act_ext[1:0]];

	assign col_inc = {1'b0, cur_col} + (CW+1)'(1);
	assign tab_sum = {1'b0, cur_col} + TAB_MOD;
	assign tab_col = (tab_sum >= COL_LIMIT) ? CW'(tab_sum - COL_LIMIT) : tab_sum[CW-1:0];
	assign row_inc = {1'b0, cur_row} + (RW+1)'(1);
	// past the bottom: clamp when scrolling, back to the top when wrapping
	assign row_adv = (row_inc >= ROW_LIMIT) ? (scroll_mode ? ROW_LAST : '0)
		: row_inc[RW-1:0];

	always_comb begin
		step_col    = cur_col;
		step_row    = cur_row;
		step_wcol   = cur_col;
		step_we     = 1'b0;
		step_scroll = 1'b0;
		step_wdata  = item.char_code;
		case (item.char_code)
			CHR_LF: begin
				step_col = '0;
				step_row = row_adv;
			end
			CHR_CR: begin
				step_col = '0;
			end
			CHR_BS: begin
				// blank the previous cell, nothing at the left margin
				if (cur_col != '0) begin
					step_col   = cur_col - CW'(1);
					step_wcol  = cur_col - CW'(1);
					step_we    = 1'b1;
					step_wdata = BLANK_CHAR;
				end
			end
			CHR_TAB: begin
				step_col = tab_col;
			end
			default: begin
				step_we = 1'b1;
				if (col_inc == COL_LIMIT) begin
					step_col    = '0;
					step_row    = row_adv;
					step_scroll = scroll_mode;
				end else begin
					step_col = col_inc[CW-1:0];
				end
			end
		endcase
	end

	// next state, RAM control and handshake
	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		load_out   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = {act_q, item.read_row[RW-1:0], item.read_col[CW-1:0]};
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				if (clr_addr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = ST_RESP;
					unique case (kind)
						KIND_CHAR: begin
							ram_we    = step_we;
							ram_waddr = {act_q, cur_row, step_wcol};
							ram_wdata = step_wdata;
							if (step_scroll) begin
								state_d = ST_COPY;
							end
						end
						KIND_READ: begin
							ram_re = rd_in_range;
						end
						KIND_SELECT, KIND_REFRESH_DONE: begin
						end
					endcase
				end
			end
			ST_COPY: begin
				// read one row below, write it back in the following cycle
				ram_re    = 1'b1;
				ram_raddr = {act_q, ptr_row_q, ptr_col_q};
				if (ptr_row_q == ROW_LAST && ptr_col_q == COL_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_BLANK;
			end
			ST_BLANK: begin
				ram_we    = 1'b1;
				ram_waddr = {act_q, ROW_LAST, ptr_col_q};
				ram_wdata = BLANK_CHAR;
				if (ptr_col_q == COL_LAST) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// pending copy write owns the write port during COPY and DRAIN
		if (wr_s1) begin
			ram_we    = 1'b1;
			ram_waddr = waddr_s1;
			ram_wdata = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sweep, copy pointers and write pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			ptr_row_q  <= '0;
			ptr_col_q  <= '0;
			wr_s1      <= 1'b0;
		end else begin
			wr_s1 <= (state_q == ST_COPY);
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (accept && kind == KIND_CHAR && step_scroll) begin
				ptr_row_q <= RW'(1);
				ptr_col_q <= '0;
			end else if (state_q == ST_COPY) begin
				if (ptr_col_q == COL_LAST) begin
					ptr_col_q <= '0;
					ptr_row_q <= ptr_row_q + RW'(1);
				end else begin
					ptr_col_q <= ptr_col_q + CW'(1);
				end
			end else if (state_q == ST_DRAIN) begin
				ptr_col_q <= '0;
			end else if (state_q == ST_BLANK) begin
				ptr_col_q <= ptr_col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= {act_q, ptr_row_q - RW'(1), ptr_col_q};
	end

	// terminal state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TERMINAL_COUNT; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
			flag_q   <= '0;
			act_q    <= '0;
			scroll_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				scroll_q <= cfg_wr_data;
			end
			if (accept) begin
				unique case (kind)
					KIND_CHAR: begin
						col_q[act_q]  <= step_col;
						row_q[act_q]  <= step_row;
						flag_q[act_q] <= 1'b1;
					end
					KIND_SELECT: begin
						if (tty_in_range) begin
							act_q <= item.tty_number[TW-1:0];
							flag_q[item.tty_number[TW-1:0]] <= 1'b1;
						end
					end
					KIND_REFRESH_DONE: begin
						flag_q[act_q] <= 1'b0;
					end
					KIND_READ: begin
					end
				endcase
			end
		end
	end

	// per-item result flags
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q      <= (kind == KIND_SELECT) && !tty_in_range;
			cell_sel_q <= (kind == KIND_READ) && rd_in_range;
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_cell_q <= cell_sel_q ? ram_rdata : '0;
			out_col_q  <= COL_W'(col_q[act_q]);
			out_row_q  <= ROW_W'(row_q[act_q]);
			out_idx_q  <= IDX_W'(act_q);
			out_flag_q <= flag_q[act_q];
			out_err_q  <= err_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.cell_char       = out_cell_q;
	assign result.cursor_col      = out_col_q;
	assign result.cursor_row      = out_row_q;
	assign result.active_index    = out_idx_q;
	assign result.refresh_pending = out_flag_q;
	assign result.select_error    = out_err_q;

	ttb_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(DEPTH)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

`ifndef SYNTHESIS
	// copy write never hits the address being read in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY && wr_s1) |-> (waddr_s1 != ram_raddr))
		else $error("scroll copy write collides with read");

	// cursor of the active terminal stays on screen
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |-> (row_q[act_q] <= ROW_LAST && col_q[act_q] <= COL_LAST))
		else $error("cursor off screen");

	// an overflow on a scrolling terminal starts the screen copy
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_CHAR && step_scroll) |=> (state_q == ST_COPY))
		else $error("scroll not started");

	// a finished result waits while the output register is still taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && out_valid_q && !result.ready) |=>
		(state_q == ST_RESP && out_valid_q))
		else $error("result overwritten under stall");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: verification of text_terminal_buffer
// Sends character, select, read and refresh-done transactions under random
// idling and back pressure. A screen model in this file predicts every
// result, and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
	import ttb_pkg::*;

	localparam int WIDTH       = DEF_SCREEN_WIDTH;
	localparam int HEIGHT      = DEF_SCREEN_HEIGHT;
	localparam int TTYS        = DEF_TERMINAL_COUNT;
	localparam int TAB         = DEF_TAB_STEP;
	// This bound on cycles without any transaction leaves a wide margin over
	// the clearing sweep after reset and over a scroll.
	localparam int QUIET_LIMIT = 60000;

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] char_code;
		logic [TTY_W-1:0]  tty_number;
		logic [ROW_W-1:0]  read_row;
		logic [COL_W-1:0]  read_col;
	} term_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] cell_char;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [IDX_W-1:0]  active_index;
		logic              refresh_pending;
		logic              select_error;
	} term_status_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [SCROLL_BITS-1:0] cfg_wr_data;

	ttb_item_if   item_ch ();
	ttb_result_if result_ch ();

	text_terminal_buffer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Screen model: cells, cursors, refresh flags, active terminal, scroll bits.
	logic [CHAR_W-1:0]      screen_mem [TTYS][HEIGHT][WIDTH];
	int                     cur_col [TTYS];
	int                     cur_row [TTYS];
	bit                     refresh_flag [TTYS];
	int                     model_term;
	logic [SCROLL_BITS-1:0] scroll_mask;

	// Results predicted for accepted items, oldest first.
	term_status_t pending_status [$];

	int mismatch_count = 0;
	bit steady_flow    = 1'b0;  // suppress random idling on both channels
	int hold_cycles    = 0;     // receiver holds ready low while this counts down
	int quiet_cycles   = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Advance the screen model by one item and return the result it should give.
	function automatic term_status_t screen_step(term_item_t it);
		term_status_t st;
		int t;
		int col;
		int row;
		int r;
		int c;
		st = '0;
		case (it.kind)
		KIND_CHAR: begin
			t   = model_term;
			col = cur_col[t];
			row = cur_row[t];
			case (it.char_code)
			CHR_LF: begin
				col = 0;
				row++;
			end
			CHR_CR: col = 0;
			CHR_BS: begin
				// blank the cell left of the cursor; nothing at column 0
				if (col > 0) begin
					col--;
					screen_mem[t][row][col] = BLANK_CHAR;
				end
			end
			CHR_TAB: col = (col + TAB) % WIDTH;
			default: begin
				screen_mem[t][row][col] = it.char_code;
				col++;
			end
			endcase
			if (scroll_mask[t]) begin
				// overflow scrolls on any row; the row never leaves the screen
				if (col >= WIDTH) begin
					col = 0;
					row++;
					for (r = 0; r < HEIGHT - 1; r++)
						for (c = 0; c < WIDTH; c++)
							screen_mem[t][r][c] = screen_mem[t][r + 1][c];
					for (c = 0; c < WIDTH; c++)
						screen_mem[t][HEIGHT - 1][c] = BLANK_CHAR;
				end
				if (row >= HEIGHT)
					row = HEIGHT - 1;
			end else begin
				if (col >= WIDTH) begin
					col = 0;
					row++;
				end
				if (row >= HEIGHT)
					row = 0;
			end
			cur_col[t]      = col;
			cur_row[t]      = row;
			refresh_flag[t] = 1'b1;
		end
		KIND_SELECT: begin
			if (int'(it.tty_number) < TTYS) begin
				model_term = int'(it.tty_number);
				refresh_flag[model_term] = 1'b1;
			end else begin
				st.select_error = 1'b1;
			end
		end
		KIND_READ: begin
			if (int'(it.read_row) < HEIGHT && int'(it.read_col) < WIDTH)
				st.cell_char = screen_mem[model_term][it.read_row][it.read_col];
		end
		default: refresh_flag[model_term] = 1'b0;
		endcase
		st.cursor_col      = COL_W'(cur_col[model_term]);
		st.cursor_row      = ROW_W'(cur_row[model_term]);
		st.active_index    = model_term[IDX_W-1:0];
		st.refresh_pending = refresh_flag[model_term];
		return st;
	endfunction

	// Offer one item and hold it until the block takes it. The fields that the
	// kind does not use carry random values. Enter and leave at a rising edge.
	task automatic send_item(kind_t kind, int arg_a, int arg_b);
		term_item_t it;
		it.kind       = kind;
		it.char_code  = CHAR_W'($urandom);
		it.tty_number = TTY_W'($urandom);
		it.read_row   = ROW_W'($urandom);
		it.read_col   = COL_W'($urandom);
		case (kind)
		KIND_CHAR:   it.char_code = CHAR_W'(arg_a);
		KIND_SELECT: it.tty_number = TTY_W'(arg_a);
		KIND_READ: begin
			it.read_row = ROW_W'(arg_a);
			it.read_col = COL_W'(arg_b);
		end
		default: ;
		endcase
		while (!steady_flow && $urandom_range(0, 99) < 29) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.kind       <= it.kind;
		item_ch.char_code  <= it.char_code;
		item_ch.tty_number <= it.tty_number;
		item_ch.read_row   <= it.read_row;
		item_ch.read_col   <= it.read_col;
		@(posedge clk);
		while (item_ch.ready !== 1'b1)
			@(posedge clk);
		pending_status.push_back(screen_step(it));
	endtask

	// Drop valid and wait until every predicted result has come back, then
	// let the block settle.
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_scroll(logic [SCROLL_BITS-1:0] mask);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mask;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		scroll_mask = mask;
	endtask

	task automatic send_text_line(int len);
		for (int i = 0; i < len; i++)
			send_item(KIND_CHAR, $urandom_range(32, 126), 0);
	endtask

	// Mixed traffic: lines of text (some long enough to overflow the column),
	// runs of newlines (some long enough to reach the bottom row), and single random items.
	task automatic run_random(int count);
		int sent;
		int len;
		int pick;
		int code;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 90)
					: $urandom_range(3, 20);
				if (len > count - sent)
					len = count - sent;
				send_text_line(len);
				sent += len;
			end else if (pick < 32) begin
				len = $urandom_range(1, 28);
				if (len > count - sent)
					len = count - sent;
				for (int i = 0; i < len; i++)
					send_item(KIND_CHAR, int'(CHR_LF), 0);
				sent += len;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					if ($urandom_range(0, 99) < 30) begin
						case ($urandom_range(0, 3))
						0:       code = int'(CHR_BS);
						1:       code = int'(CHR_TAB);
						2:       code = int'(CHR_LF);
						default: code = int'(CHR_CR);
						endcase
					end else begin
						code = $urandom_range(0, 255);
					end
					send_item(KIND_CHAR, code, 0);
				end else if (pick < 65) begin
					send_item(KIND_SELECT, ($urandom_range(0, 9) < 7) ?
						$urandom_range(0, TTYS - 1) : $urandom_range(0, 15), 0);
				end else if (pick < 90) begin
					// mostly cells on the screen, half on the cursor row
					if ($urandom_range(0, 9) < 8)
						send_item(KIND_READ, $urandom_range(0, 1) ? cur_row[model_term]
							: $urandom_range(0, HEIGHT - 1), $urandom_range(0, WIDTH - 1));
					else
						send_item(KIND_READ, $urandom_range(0, 31), $urandom_range(0, 127));
				end else begin
					send_item(KIND_REFRESH_DONE, 0, 0);
				end
				sent++;
			end
		end
	endtask

	// Corner cases on terminal 0 and 3 with wrap mode.
	task automatic test_edge_cases();
		write_scroll(4'h0);
		send_item(KIND_READ, 0, 0);
		send_item(KIND_CHAR, 0, 0);              // code zero is stored like any other
		send_item(KIND_CHAR, 255, 0);
		send_item(KIND_CHAR, int'("A"), 0);
		send_item(KIND_CHAR, int'(CHR_BS), 0);   // blank the cell left of the cursor
		send_item(KIND_READ, 0, 2);
		send_item(KIND_CHAR, int'(CHR_CR), 0);
		send_item(KIND_CHAR, int'(CHR_BS), 0);   // backspace at column 0 does nothing
		send_item(KIND_CHAR, int'(CHR_TAB), 0);
		send_item(KIND_CHAR, int'(CHR_LF), 0);
		send_item(KIND_REFRESH_DONE, 0, 0);
		send_item(KIND_READ, 0, 1);
		send_item(KIND_READ, 31, 127);           // reads off the screen return zero
		send_item(KIND_READ, HEIGHT, 0);
		send_item(KIND_READ, 0, WIDTH);
		send_item(KIND_SELECT, 15, 0);           // terminals beyond the count flag an error
		send_item(KIND_SELECT, TTYS, 0);
		send_item(KIND_SELECT, TTYS - 1, 0);
		send_item(KIND_CHAR, int'("z"), 0);
		send_item(KIND_READ, HEIGHT - 1, WIDTH - 1);
		send_item(KIND_SELECT, TTYS - 1, 0);     // reselect sets the flag again
		send_item(KIND_REFRESH_DONE, 0, 0);
		send_item(KIND_SELECT, 0, 0);
		send_item(KIND_READ, 0, 0);
	endtask

	// Wrap mode everywhere: column overflow to the next row, rows wrap to the top.
	task automatic test_wrap_mode();
		send_text_line(82);
		run_random(40);
	endtask

	// Scroll mode everywhere: overflow shifts the screen, newline clamps at bottom.
	task automatic test_scroll_mode();
		write_scroll(4'hF);
		send_text_line(82);
		run_random(40);
	endtask

	// Alternate scroll bits; the first half runs with no idling at all.
	task automatic test_mixed_scroll();
		write_scroll(4'h5);
		steady_flow = 1'b1;
		run_random(30);
		drain_results();
		steady_flow = 1'b0;
		write_scroll(4'hA);
		run_random(30);
	endtask

	// Receiver holds off for a long stretch while items keep coming, so the
	// block fills up and stalls its input.
	task automatic test_back_pressure();
		drain_results();
		hold_cycles = 400;
		run_random(40);
	endtask

	// Sender pauses mid-stream until every result is back.
	task automatic test_drain_pause();
		write_scroll(4'h0);
		run_random(20);
		drain_results();
		run_random(20);
	endtask

	task automatic check_status();
		term_status_t want;
		if (pending_status.size() == 0) begin
			$error("result transaction with no item pending");
			mismatch_count++;
			return;
		end
		want = pending_status.pop_front();
		if (result_ch.cell_char !== want.cell_char) begin
			$error("cell_char expected %0d actual %0d", want.cell_char, result_ch.cell_char);
			mismatch_count++;
		end
		if (result_ch.cursor_col !== want.cursor_col) begin
			$error("cursor_col expected %0d actual %0d", want.cursor_col,
				result_ch.cursor_col);
			mismatch_count++;
		end
		if (result_ch.cursor_row !== want.cursor_row) begin
			$error("cursor_row expected %0d actual %0d", want.cursor_row,
				result_ch.cursor_row);
			mismatch_count++;
		end
		if (result_ch.active_index !== want.active_index) begin
			$error("active_index expected %0d actual %0d", want.active_index,
				result_ch.active_index);
			mismatch_count++;
		end
		if (result_ch.refresh_pending !== want.refresh_pending) begin
			$error("refresh_pending expected %0d actual %0d", want.refresh_pending,
				result_ch.refresh_pending);
			mismatch_count++;
		end
		if (result_ch.select_error !== want.select_error) begin
			$error("select_error expected %0d actual %0d", want.select_error,
				result_ch.select_error);
			mismatch_count++;
		end
	endtask

	// Receiver: check each result transaction, then choose the next ready.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
				check_status();
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_ch.ready <= 1'b0;
			end else if (steady_flow) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= 29);
			end
		end
	end

	// Watchdog: end the run when no transaction moves on either channel for
	// too long.
	always @(posedge clk) begin
		if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
				(result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[text_terminal_buffer] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		item_ch.valid      = 1'b0;
		item_ch.kind       = '0;
		item_ch.char_code  = '0;
		item_ch.tty_number = '0;
		item_ch.read_row   = '0;
		item_ch.read_col   = '0;
		foreach (screen_mem[t, r, c])
			screen_mem[t][r][c] = '0;
		foreach (cur_col[t]) begin
			cur_col[t]      = 0;
			cur_row[t]      = 0;
			refresh_flag[t] = 1'b0;
		end
		model_term  = 0;
		scroll_mask = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_edge_cases();
		test_wrap_mode();
		test_scroll_mode();
		test_mixed_scroll();
		test_back_pressure();
		test_drain_pause();

		// hold until every result is in, then let the block go quiet
		drain_results();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("[text_terminal_buffer] OK");
		else
			$display("[text_terminal_buffer] ERROR");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/ttb_pkg.sv
hw/rtl/ttb_item_if.sv
hw/rtl/ttb_result_if.sv
hw/rtl/ttb_ram.sv
hw/rtl/text_terminal_buffer.sv
tb/sv/testbench.sv
